[rtl/nearest_palette_color_matcher_top_defines.svh]
// Assertion macros for the palette matcher RTL.
// No dependencies; included by the top level, which checks its own logic.
`ifndef NEAREST_PALETTE_COLOR_MATCHER_TOP_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MATCHER_TOP_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define NPCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante.
`define NPCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/npcm_pkg.sv]
// Types, palette constants and step functions for the palette matcher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package npcm_pkg;

    localparam int NUM_COLORS  = 16;
    localparam int NUM_PAIRS   = 3;
    localparam int ROOT_STEPS  = 17;
    localparam int ROOT_STAGES = 9;

    typedef logic [3:0]  color_idx_t;
    typedef logic [31:0] argb_t;
    typedef logic [7:0]  chan_t;
    typedef logic [17:0] sq_sum_t;
    typedef logic [16:0] root_t;
    typedef logic [19:0] rem_t;
    typedef logic [18:0] dist_t;

    typedef struct packed {
        rem_t    rem;
        root_t   root;
        sq_sum_t sum;
    } root_st_t;

    typedef struct packed {
        color_idx_t idx;
        dist_t      score;
    } cand_t;

    localparam argb_t PAL_WORDS [NUM_COLORS] = '{
        32'hff000000, 32'hffb21818, 32'hff18b218, 32'hffb26818,
        32'hff1818b2, 32'hffb218b2, 32'hff18b2b2, 32'hffb2b2b2,
        32'hff686868, 32'hffff5454, 32'hff54ff54, 32'hffffff54,
        32'hff5454ff, 32'hffff54ff, 32'hff54ffff, 32'hffffffff
    };

    // One digit of the restoring square root. The radicand is the sum
    // followed by sixteen zero bits, so two sum bits enter per step and
    // zeros follow once the sum has been shifted out.
    function automatic root_st_t root_step(root_st_t s);
        rem_t     cur;
        rem_t     trial;
        root_st_t o;
        cur   = {s.rem[17:0], s.sum[17:16]};
        trial = {1'b0, s.root, 2'b01};
        o.sum = {s.sum[15:0], 2'b00};
        if (cur >= trial)
        begin
            o.rem  = cur - trial;
            o.root = {s.root[15:0], 1'b1};
        end
        else
        begin
            o.rem  = cur;
            o.root = {s.root[15:0], 1'b0};
        end
        return o;
    endfunction

    // The higher index wins on equal distance.
    function automatic cand_t best_of(cand_t lo, cand_t hi);
        return (hi.score <= lo.score) ? hi : lo;
    endfunction

endpackage

`default_nettype wire

[rtl/npcm_root.sv]
// Pipelined integer square root of (sum << 16), two digits per stage but one in the last.
// Depends on npcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npcm_root
    import npcm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    en,
    input  wire sq_sum_t sum,
    output root_t        root
);

    root_st_t st_reg  [ROOT_STAGES];
    root_st_t st_next [ROOT_STAGES];
    root_st_t src     [ROOT_STAGES];

    for (genvar st = 0; st < ROOT_STAGES; st++)
    begin : g_stg
        if (st == 0)
        begin : g_first
            assign src[st] = '{rem: '0, root: '0, sum: sum};
        end
        else
        begin : g_rest
            assign src[st] = st_reg[st-1];
        end

        if (2 * st + 1 < ROOT_STEPS)
        begin : g_two
            assign st_next[st] = root_step(root_step(src[st]));
        end
        else
        begin : g_one
            assign st_next[st] = root_step(src[st]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[st] <= st_next[st];
            end
        end
    end

    assign root = st_reg[ROOT_STAGES-1].root;

endmodule

`default_nettype wire

[rtl/npcm_argmin.sv]
// Adds the three roots per entry and picks the nearest entry in a
// registered tree, then looks up the palette word. Depends on npcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npcm_argmin
    import npcm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire root_t      roots [NUM_COLORS][NUM_PAIRS],
    output color_idx_t      idx,
    output argb_t           word
);

    dist_t      dist_reg  [NUM_COLORS];
    cand_t      grp_reg   [4];
    cand_t      grp_next  [4];
    cand_t      best_next;
    color_idx_t idx_reg;
    argb_t      word_reg;

    always_comb
    begin
        cand_t c [NUM_COLORS];
        for (int i = 0; i < NUM_COLORS; i++)
        begin
            c[i] = '{idx: color_idx_t'(i), score: dist_reg[i]};
        end
        for (int g = 0; g < 4; g++)
        begin
            grp_next[g] = best_of(best_of(c[4*g], c[4*g+1]),
                                  best_of(c[4*g+2], c[4*g+3]));
        end
        best_next = best_of(best_of(grp_reg[0], grp_reg[1]),
                            best_of(grp_reg[2], grp_reg[3]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_COLORS; i++)
            begin
                dist_reg[i] <= dist_t'(roots[i][0]) + dist_t'(roots[i][1])
                             + dist_t'(roots[i][2]);
            end
            grp_reg  <= grp_next;
            idx_reg  <= best_next.idx;
            word_reg <= PAL_WORDS[best_next.idx];
        end
    end

    assign idx  = idx_reg;
    assign word = word_reg;

endmodule

`default_nettype wire

[rtl/nearest_palette_color_matcher_top.sv]
// Top level of the nearest palette color matcher.
// Depends on npcm_pkg, npcm_root, npcm_argmin and the assertion header.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    pixel_argb
//   output    out_valid / out_ready  palette_index, matched_argb
//
// One pixel is taken per clock while the output is not stalled; each
// transfer in gives exactly one transfer out. The latency is set by the
// square root pipeline: 17 root digits, two per stage but one in the last,
// behind one stage of squares and three stages of sum and compare.
// Reset clears only the valid bits; data registers hold whatever they held.
// A stall at the output freezes the whole pipeline, and in_ready falls with
// it, so nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_palette_color_matcher_top_defines.svh"

module nearest_palette_color_matcher_top
    import npcm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] pixel_argb,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       palette_index,
    output logic [31:0]      matched_argb
);

    // Squares, root stages, then sum, group compare and final compare.
    localparam int LATENCY = 1 + ROOT_STAGES + 3;

    logic             en;
    logic [LATENCY-1:0] vld_reg;
    logic [LATENCY-1:0] vld_next;
    sq_sum_t          sum_reg  [NUM_COLORS][NUM_PAIRS];
    sq_sum_t          sum_next [NUM_COLORS][NUM_PAIRS];
    root_t            roots    [NUM_COLORS][NUM_PAIRS];

    // The pipeline moves whenever the last stage is empty or being taken.
    assign en       = !vld_reg[LATENCY-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[LATENCY-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage one: channel differences, squares and the three pair sums
    // for every palette entry. Alpha is dropped here.
    always_comb
    begin
        logic signed [8:0]  d  [3];
        logic signed [17:0] p;
        logic [15:0]        sq [3];
        argb_t              w;
        for (int i = 0; i < NUM_COLORS; i++)
        begin
            w = PAL_WORDS[i];
            for (int c = 0; c < 3; c++)
            begin
                d[c]  = $signed({1'b0, pixel_argb[16-8*c +: 8]})
                      - $signed({1'b0, w[16-8*c +: 8]});
                p     = d[c] * d[c];
                sq[c] = p[15:0];
            end
            sum_next[i][0] = sq_sum_t'(sq[0]) + sq_sum_t'(sq[1]);
            sum_next[i][1] = sq_sum_t'(sq[0]) + sq_sum_t'(sq[2]);
            sum_next[i][2] = sq_sum_t'(sq[1]) + sq_sum_t'(sq[2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    // Forty-eight root pipelines run in lockstep under the shared enable.
    for (genvar i = 0; i < NUM_COLORS; i++)
    begin : g_color
        for (genvar j = 0; j < NUM_PAIRS; j++)
        begin : g_pair
            npcm_root u_root (
                .clk  (clk),
                .en   (en),
                .sum  (sum_reg[i][j]),
                .root (roots[i][j])
            );
        end
    end

    npcm_argmin u_argmin (
        .clk   (clk),
        .en    (en),
        .roots (roots),
        .idx   (palette_index),
        .word  (matched_argb)
    );

    assign out_valid = vld_reg[LATENCY-1];

    `NPCM_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, vld_reg[0], "transfer in lost")
    `NPCM_ASSERT_NEXT(a_freeze, !en, $stable(vld_reg), "valid bits moved during stall")
    `NPCM_ASSERT_NOW(a_word_idx, out_valid, matched_argb == PAL_WORDS[palette_index],
        "palette word does not match index")

endmodule

`default_nettype wire
